>>> hdl/base64_stream_encoder_unit_macros.svh
// Assertion macros shared by the Base64 stream encoder RTL.
`ifndef BASE64_STREAM_ENCODER_UNIT_MACROS_SVH
`define BASE64_STREAM_ENCODER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define B64E_CHECK_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define B64E_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/b64e_pkg.sv
// Shared types, character codes and alphabet lookup for the Base64 encoder.
package b64e_pkg;

  localparam logic [6:0] CHAR_PAD    = 7'h3D;  // '='
  localparam logic [6:0] CHAR_PLUS   = 7'h2B;  // '+'
  localparam logic [6:0] CHAR_SLASH  = 7'h2F;  // '/'
  localparam logic [6:0] CHAR_MINUS  = 7'h2D;  // '-'
  localparam logic [6:0] CHAR_USCORE = 7'h5F;  // '_'

  localparam logic [5:0] IDX_UPPER_END = 6'd26;
  localparam logic [5:0] IDX_LOWER_END = 6'd52;
  localparam logic [5:0] IDX_DIGIT_END = 6'd62;
  localparam logic [5:0] IDX_PLUS      = 6'd62;

  // Number of bits held back between bytes.
  typedef enum logic [1:0] {
    HELD_0,
    HELD_2,
    HELD_4
  } held_t;

  // One classified byte: up to two sextets, then up to two pads.
  typedef struct packed {
    logic [5:0] sym1;
    logic [5:0] sym0;
    logic       two_chars;
    logic [1:0] npad;
    logic       fin;
  } b64e_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } b64e_qstat_t;

  function automatic logic [6:0] b64e_map(input logic [5:0] idx, input logic url);
    logic [6:0] c;
    if (idx < IDX_UPPER_END) begin
      c = 7'h41 + {1'b0, idx};
    end else if (idx < IDX_LOWER_END) begin
      c = 7'h47 + {1'b0, idx};
    end else if (idx < IDX_DIGIT_END) begin
      c = {1'b0, idx} - 7'd4;
    end else if (idx == IDX_PLUS) begin
      c = url ? CHAR_MINUS : CHAR_PLUS;
    end else begin
      c = url ? CHAR_USCORE : CHAR_SLASH;
    end
    return c;
  endfunction

endpackage

>>> hdl/base64_stream_encoder_unit.sv
// A byte accepted is written to the queue, then its characters pass through the out_char register to m_tdata.
// Throughput: one byte request per cycle while the queue has room; output is one character
//   per cycle while the output register is free (m_tvalid low or m_tready high).
// The output character rate of the back side is what sets the sustained byte rate.
// Reset (rst, synchronous, active high) clears held bits, the queue, the output valid flag
//   and url_safe; the block accepts requests in the first cycle after reset.
`include "base64_stream_encoder_unit_macros.svh"

module base64_stream_encoder_unit import b64e_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4  // entries between front and back, 2 or more
) (
  input  logic        clk,
  input  logic        rst,
  // input byte stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // final_byte
  // encoded character stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [6:0] out_char, [7] zero
  output logic        m_tlast,   // last_char
  // configuration, register 0 (url_safe) at byte address 0
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic        url_safe;
  logic        cfg_wr;
  logic        q_push, q_pop;
  b64e_entry_t q_in, q_head;
  b64e_qstat_t q_stat;
  logic [6:0]  mchr;
  logic        char_ok;
  logic        url_ok;
  logic        out_free;

  // Only one register: address bit 2 clear selects it, anything else reads zero.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : {31'd0, url_safe};

  always_ff @(posedge clk) begin
    if (rst) begin
      url_safe <= 1'b0;
    end else if (cfg_wr) begin
      url_safe <= pwdata[0];
    end
  end

  // Front: splits each byte into sextets, tracks the 0/2/4 bits held back.
  b64e_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .qstat      (q_stat),
    .push       (q_push),
    .push_entry (q_in)
  );

  // Queue lets the input keep taking bytes while the output is stalled.
  b64e_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .head       (q_head),
    .qstat      (q_stat)
  );

  // Back: maps sextets to ASCII, adds '=' pads, marks the final character.
  b64e_back u_back (
    .clk      (clk),
    .rst      (rst),
    .url_safe (url_safe),
    .head     (q_head),
    .qstat    (q_stat),
    .pop      (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  assign mchr     = m_tdata[6:0];
  assign char_ok  = !m_tdata[7] &&
                    (mchr inside {[7'h41:7'h5A], [7'h61:7'h7A], [7'h30:7'h39],
                                  CHAR_PLUS, CHAR_SLASH, CHAR_MINUS, CHAR_USCORE,
                                  CHAR_PAD});
  assign url_ok   = (mchr != CHAR_PLUS) && (mchr != CHAR_SLASH);
  assign out_free = !m_tvalid || m_tready;

  `B64E_CHECK_NOW(a_char_legal, m_tvalid, char_ok, "character outside the alphabet")
  `B64E_CHECK_NOW(a_url_alphabet, m_tvalid && url_safe, url_ok, "plus or slash in URL mode")
  `B64E_CHECK_NEXT(a_back_drains, !q_stat.empty && out_free, m_tvalid, "queued entry stuck")

endmodule

>>> hdl/b64e_front.sv
// Input side: takes bytes, tracks held-back bits, classifies each byte into sextets and pads.
module b64e_front import b64e_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // final_byte
  input  b64e_qstat_t qstat,
  output logic        push,
  output b64e_entry_t push_entry
);

  held_t      held, held_next;
  logic [3:0] lbits, lbits_next;

  assign s_tready = !qstat.full;
  assign push     = s_tvalid && s_tready;

  always_comb begin
    push_entry.fin = s_tlast;
    case (held)
      HELD_0: begin
        push_entry.sym0      = s_tdata[7:2];
        push_entry.sym1      = {s_tdata[1:0], 4'b0000};
        push_entry.two_chars = s_tlast;
        push_entry.npad      = s_tlast ? 2'd2 : 2'd0;
        held_next            = HELD_2;
        lbits_next           = {2'b00, s_tdata[1:0]};
      end
      HELD_2: begin
        push_entry.sym0      = {lbits[1:0], s_tdata[7:4]};
        push_entry.sym1      = {s_tdata[3:0], 2'b00};
        push_entry.two_chars = s_tlast;
        push_entry.npad      = s_tlast ? 2'd1 : 2'd0;
        held_next            = HELD_4;
        lbits_next           = s_tdata[3:0];
      end
      default: begin
        push_entry.sym0      = {lbits, s_tdata[7:6]};
        push_entry.sym1      = s_tdata[5:0];
        push_entry.two_chars = 1'b1;
        push_entry.npad      = 2'd0;
        held_next            = HELD_0;
        lbits_next           = 4'd0;
      end
    endcase
    if (s_tlast) begin
      held_next  = HELD_0;
      lbits_next = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held  <= HELD_0;
      lbits <= 4'd0;
    end else if (push) begin
      held  <= held_next;
      lbits <= lbits_next;
    end
  end

endmodule

>>> hdl/b64e_fifo.sv
// Short queue of classified entries between the front and back sides.
module b64e_fifo import b64e_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  b64e_entry_t push_entry,
  input  logic        pop,
  output b64e_entry_t head,
  output b64e_qstat_t qstat
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  b64e_entry_t      mem [DEPTH];
  logic [PTR_W-1:0] rd_ptr, wr_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign qstat.full  = (count == CNT_W'(DEPTH));
  assign qstat.empty = (count == '0);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign head        = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> hdl/b64e_back.sv
// Output side: walks each queued entry one character per cycle, while the output register is free, into it.
module b64e_back import b64e_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        url_safe,
  input  b64e_entry_t head,
  input  b64e_qstat_t qstat,
  output logic        pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [6:0] out_char, [7] zero
  output logic        m_tlast    // last_char
);

  logic [1:0] sel;
  logic [1:0] last_sel;
  logic       slot_free, fire, at_end;
  logic [6:0] chr;
  logic [6:0] out_char;

  assign slot_free = !m_tvalid || m_tready;
  assign fire      = !qstat.empty && slot_free;
  assign last_sel  = {1'b0, head.two_chars} + head.npad;
  assign at_end    = (sel == last_sel);
  assign pop       = fire && at_end;
  assign m_tdata   = {1'b0, out_char};

  always_comb begin
    if (sel == 2'd0) begin
      chr = b64e_map(head.sym0, url_safe);
    end else if (sel == 2'd1 && head.two_chars) begin
      chr = b64e_map(head.sym1, url_safe);
    end else begin
      chr = CHAR_PAD;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_char <= chr;
      m_tlast  <= head.fin && at_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      sel      <= 2'd0;
    end else begin
      if (fire) begin
        m_tvalid <= 1'b1;
        sel      <= at_end ? 2'd0 : sel + 2'd1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

>>> tb/base64_stream_encoder_unit_checker.sv
`timescale 1ns / 1ps
// Checker for the Base64 stream encoder: predicts the character stream and compares it.
module base64_stream_encoder_unit_checker import b64e_pkg::*; #(
  parameter logic [2:0] URL_SAFE_ADDR = 3'd0
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // final_byte
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,   // [6:0] out_char, [7] zero
  input  logic        m_tlast,   // last_char
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int unsigned failures,
  output int unsigned chars_due
);

  typedef struct packed {
    logic [6:0] code;
    logic       last;
  } enc_char_t;

  string      alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  enc_char_t  due_chars[$];
  logic       url_mode;
  logic [3:0] carry_bits;   // held-back bits, right aligned
  held_t      carry_held;

  function automatic logic [6:0] sextet_char(input logic [5:0] sx);
    byte        b;
    logic [6:0] c;
    b = alphabet.getc(sx);
    c = b[6:0];
    if (url_mode && c == CHAR_PLUS) c = CHAR_MINUS;
    else if (url_mode && c == CHAR_SLASH) c = CHAR_USCORE;
    return c;
  endfunction

  task automatic predict_chars(input logic [7:0] data, input logic fin);
    logic [11:0] acc;
    logic [11:0] sh;
    logic [6:0]  burst [4];
    enc_char_t   e;
    int          held;
    int          nbits;
    int          n;
    int          npad;
    held  = (carry_held == HELD_0) ? 0 : (carry_held == HELD_2) ? 2 : 4;
    acc   = {carry_bits, data};
    nbits = held + 8;
    n     = 0;
    while (nbits >= 6) begin
      nbits -= 6;
      sh = acc >> nbits;
      burst[n] = sextet_char(sh[5:0]);
      n++;
    end
    if (fin) begin
      if (nbits > 0) begin
        sh = acc << (6 - nbits);
        burst[n] = sextet_char(sh[5:0]);
        n++;
      end
      npad = (held == 0) ? 2 : (held == 2) ? 1 : 0;
      for (int k = 0; k < npad; k++) begin
        burst[n] = CHAR_PAD;
        n++;
      end
      carry_bits = '0;
      carry_held = HELD_0;
    end else begin
      carry_bits = (nbits == 0) ? 4'h0 : (nbits == 2) ? {2'b00, acc[1:0]} : acc[3:0];
      carry_held = (nbits == 0) ? HELD_0 : (nbits == 2) ? HELD_2 : HELD_4;
    end
    for (int k = 0; k < n; k++) begin
      e.code = burst[k];
      e.last = fin && (k == n - 1);
      due_chars.push_back(e);
    end
  endtask

  always @(posedge clk) begin : watch
    enc_char_t want;
    if (rst) begin
      due_chars.delete();
      url_mode   = 1'b0;
      carry_bits = '0;
      carry_held = HELD_0;
      failures   = 0;
    end else begin
      if (psel && penable && pready && pwrite && paddr == URL_SAFE_ADDR) begin
        url_mode = pwdata[0];
      end
      if (psel && penable && pready && !pwrite && paddr == URL_SAFE_ADDR &&
          prdata !== {31'b0, url_mode}) begin
        $error("prdata: expected %h, got %h", {31'b0, url_mode}, prdata);
        failures++;
      end
      if (s_tvalid && s_tready) begin
        predict_chars(s_tdata, s_tlast);
      end
      if (m_tvalid && m_tready) begin
        if (due_chars.size() == 0) begin
          $error("unexpected character: out_char %h last_char %b", m_tdata[6:0], m_tlast);
          failures++;
        end else begin
          want = due_chars.pop_front();
          if (m_tdata[6:0] !== want.code) begin
            $error("out_char: expected %h, got %h", want.code, m_tdata[6:0]);
            failures++;
          end
          if (m_tlast !== want.last) begin
            $error("last_char: expected %b, got %b", want.last, m_tlast);
            failures++;
          end
          if (m_tdata[7] !== 1'b0) begin
            $error("m_tdata[7]: expected 0, got %b", m_tdata[7]);
            failures++;
          end
        end
      end
    end
    chars_due = due_chars.size();
  end

endmodule

>>> tb/base64_stream_encoder_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top for the Base64 stream encoder: clock, reset, stimulus, stalls and verdict.
module base64_stream_encoder_unit_tb;
  import b64e_pkg::*;

  localparam logic [2:0] ADDR_URL_SAFE = 3'd0;
  localparam logic [2:0] ADDR_NO_REG   = 3'd4;   // register index 1, not implemented
  localparam int STALL_LIMIT  = 5000;  // cycles with no handshake before giving up
  localparam int HOLD_CYCLES  = 300;   // long back-pressure stretch
  localparam int DRAIN_CYCLES = 16;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int unsigned failures;
  int unsigned chars_due;
  int          send_idle_pct;
  int          recv_idle_pct;
  bit          hold_request;
  int          hold_left;
  int          quiet_cycles;

  base64_stream_encoder_unit DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  base64_stream_encoder_unit_checker #(.URL_SAFE_ADDR(ADDR_URL_SAFE)) checker_i (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .failures (failures),
    .chars_due(chars_due)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: random tready, or a long hold-off when one is requested.
  initial begin
    m_tready  = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request && hold_left == 0) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: any handshake on either stream restarts the count.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("base64_stream_encoder_unit_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One byte request. Entered and left at a falling edge; tvalid stays high
  // between back-to-back requests and only drops in an idle gap.
  task automatic send_request(input logic [7:0] data, input logic fin);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tlast  <= fin;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Read data is compared by the checker during the access cycle.
  task automatic apb_read(input logic [2:0] addr);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Stop offering, wait for every predicted character, then let the pipe settle.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (chars_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Bias toward all-zero and all-one bytes so sextets 0 and 63 show up often.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Random messages: mostly short, now and then a long one.
  task automatic run_phase(input int send_pct, input int recv_pct, input logic url,
                           input int items, input bit with_hold);
    logic [31:0] wval;
    int          sent;
    int          len;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    wval    = $urandom;
    wval[0] = url;
    apb_write(ADDR_URL_SAFE, wval);
    apb_read(ADDR_URL_SAFE);
    if (with_hold) hold_request = 1'b1;
    sent = 0;
    while (sent < items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
      for (int k = 0; k < len; k++) send_request(pick_byte(), k == len - 1);
      sent += len;
    end
    drain();
  endtask

  initial begin
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tlast       = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    send_idle_pct = 12;
    recv_idle_pct = 75;
    hold_request  = 1'b0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // Directed, standard alphabet after reset.
    send_request(8'h00, 1'b1);                                  // two pads
    send_request(8'hFF, 1'b1);                                  // slash, two pads
    send_request(8'hFB, 1'b0); send_request(8'hFF, 1'b1);       // plus, slash, one pad
    send_request(8'hFB, 1'b0); send_request(8'hEF, 1'b0);
    send_request(8'hBF, 1'b1);                                  // no pad
    send_request(8'h4D, 1'b0); send_request(8'h61, 1'b0);
    send_request(8'h6E, 1'b1);
    // Back-to-back messages: state must restart after each final byte.
    send_request(8'h00, 1'b0); send_request(8'hFF, 1'b0);
    send_request(8'h80, 1'b0); send_request(8'h55, 1'b0);
    send_request(8'hAA, 1'b1);
    drain();

    // URL-safe with all upper bits set; a write to the unused index is dropped.
    apb_write(ADDR_URL_SAFE, 32'hFFFF_FFFF);
    apb_write(ADDR_NO_REG, 32'h0000_0000);
    apb_read(ADDR_URL_SAFE);
    send_request(8'hFF, 1'b1);
    send_request(8'hFB, 1'b0); send_request(8'hFF, 1'b1);
    send_request(8'hFB, 1'b0); send_request(8'hEF, 1'b0);
    send_request(8'hBF, 1'b1);
    drain();
    apb_write(ADDR_URL_SAFE, 32'hFFFF_FFFE);
    apb_read(ADDR_URL_SAFE);

    // Random phases: sender mostly busy, then receiver mostly busy, then no idling
    // with a long receiver hold-off so the queue fills and input stalls.
    run_phase(12, 75, 1'b1, 165, 1'b0);
    run_phase(75, 12, 1'b0, 165, 1'b0);
    run_phase(0, 0, 1'b1, 165, 1'b1);

    if (failures == 0 && chars_due == 0) begin
      $display("base64_stream_encoder_unit_tb: PASS");
    end else begin
      $display("base64_stream_encoder_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
